// File: rtl/true_lru_stack_replacement_unit_defines.svh
// Assertion macros shared by the checker of the true-LRU replacement unit.
// No dependencies; included by files that hold concurrent assertions.
`ifndef TRUE_LRU_STACK_REPLACEMENT_UNIT_DEFINES_SVH
`define TRUE_LRU_STACK_REPLACEMENT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define TLRU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("tlru assertion failed");

// Next-cycle implication, disabled while reset is held
`define TLRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("tlru assertion failed");

`endif

// File: rtl/tlru_pkg.sv
// Shared types and field widths of the true-LRU replacement unit.
// No dependencies; used by the channel interfaces and all modules.
package tlru_pkg;

  localparam int SET_IDX_W = 10;
  localparam int WAY_W     = 4;
  localparam int OUT_W     = 4;

  typedef enum logic {
    KIND_QUERY = 1'b0,
    KIND_TOUCH = 1'b1
  } kind_t;

  // Control of the item in the update stage
  typedef struct packed {
    kind_t kind;
    logic  set_ok;
    logic  way_ok;
  } tlru_req_t;

  // One result item
  typedef struct packed {
    logic [OUT_W-1:0] evict_way;
    logic [OUT_W-1:0] prior_position;
  } tlru_res_t;

endpackage

// File: rtl/tlru_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on tlru_pkg.
interface tlru_in_if import tlru_pkg::*; ();
  logic                 valid;
  logic                 ready;
  kind_t                kind;
  logic [SET_IDX_W-1:0] set_index;
  logic [WAY_W-1:0]     way;

  modport source(output valid, kind, set_index, way, input ready);
  modport sink(input valid, kind, set_index, way, output ready);
endinterface

interface tlru_out_if import tlru_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] evict_way;
  logic [OUT_W-1:0] prior_position;

  modport source(output valid, evict_way, prior_position, input ready);
  modport sink(input valid, evict_way, prior_position, output ready);
endinterface

// File: rtl/tlru_row_mem.sv
// Set-row memory of stack positions with a post-reset clearing sweep.
// Depends on tlru_pkg (import only for house consistency of types).
module tlru_row_mem import tlru_pkg::*; #(
  parameter int SETS = 1024,
  parameter int WAYS = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        rd_en,
  input  logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0]  rd_addr,
  output logic [WAYS-1:0][$clog2(WAYS)-1:0]           rd_data,
  input  logic                                        wr_en,
  input  logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0]  wr_addr,
  input  logic [WAYS-1:0][$clog2(WAYS)-1:0]           wr_data,
  output logic                                        busy
);

  localparam int AW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int PW = $clog2(WAYS);

  logic [WAYS-1:0][PW-1:0] mem [SETS];
  logic [WAYS-1:0][PW-1:0] init_row;
  logic [AW-1:0]           clr_idx_r;
  logic                    clr_busy_r;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [WAYS-1:0][PW-1:0] mem_wdata;

  // Reset row: each way sits at the position of its own number
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      init_row[w] = PW'(w);
    end
  end

  // Sweep writes the reset row; normal writes take over afterwards
  assign mem_we    = clr_busy_r | wr_en;
  assign mem_waddr = clr_busy_r ? clr_idx_r : wr_addr;
  assign mem_wdata = clr_busy_r ? init_row : wr_data;
  assign busy      = clr_busy_r;

  // Clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r  <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + AW'(1);
      if (clr_idx_r == AW'(SETS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Storage: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/tlru_row_update.sv
// Per-row victim search and promote logic for one set of stack positions.
// Depends on tlru_pkg.
module tlru_row_update import tlru_pkg::*; #(
  parameter int WAYS = 16
) (
  input  tlru_req_t                         req,
  input  logic [$clog2(WAYS)-1:0]           way_idx,
  input  logic [WAYS-1:0][$clog2(WAYS)-1:0] row,
  output logic [WAYS-1:0][$clog2(WAYS)-1:0] new_row,
  output logic                              row_we,
  output tlru_res_t                         res
);

  localparam int PW  = $clog2(WAYS);
  localparam int WXW = (PW > OUT_W) ? PW : OUT_W;

  logic [PW-1:0]    old_pos;
  logic [WXW-1:0]   old_pos_x;
  logic [OUT_W-1:0] lru_way;
  logic             is_touch;

  assign is_touch  = (req.kind == KIND_TOUCH) && req.set_ok && req.way_ok;
  assign old_pos   = row[way_idx];
  assign old_pos_x = WXW'(old_pos);

  // Victim: the way at the LRU end; a permutation holds exactly one
  always_comb begin
    lru_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (row[w] == PW'(WAYS - 1)) begin
        lru_way = lru_way | OUT_W'(w);
      end
    end
  end

  // Promote: ways nearer MRU than the old position age by one, touched way to MRU
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      if (PW'(w) == way_idx) begin
        new_row[w] = '0;
      end else if (row[w] < old_pos) begin
        new_row[w] = row[w] + PW'(1);
      end else begin
        new_row[w] = row[w];
      end
    end
  end

  assign row_we             = is_touch;
  assign res.evict_way      = ((req.kind == KIND_QUERY) && req.set_ok) ? lru_way : '0;
  assign res.prior_position = is_touch ? old_pos_x[OUT_W-1:0] : '0;

endmodule

// File: rtl/true_lru_stack_replacement_unit.sv
// True-LRU replacement unit: tracks a stack position for each way of each set.
// Requests arrive on in_ch; each one gives exactly one result on out_ch.
// A victim query (kind 0) returns the way at the LRU position; a touch
// (kind 1) moves the way to MRU and returns its prior position.
// Throughput: one item per cycle while out_ch.ready stays high. A set row is read from the row
// memory on the transfer, updated in the next cycle and written back; the
// row written by the previous item is forwarded to the next one on a match.
// The result of a transferred item passes from the update stage into the output
// register, which drives out_ch.
// Reset: a sweep rewrites every row to positions equal to way numbers, one
// row per cycle; in_ch.ready stays low until it ends.
// Stall: an output register holds the result while out_ch.ready is low; the
// update stage keeps one more item, then in_ch.ready drops.
// Out-of-range sets, and touches of out-of-range ways, give zero results and leave the state alone.
// Depends on tlru_pkg, tlru_if, tlru_row_mem and tlru_row_update.
module true_lru_stack_replacement_unit import tlru_pkg::*; #(
  parameter int SETS = 1024,
  parameter int WAYS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  tlru_in_if.sink    in_ch,
  tlru_out_if.source out_ch
);

  localparam int AW  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int PW  = $clog2(WAYS);
  localparam int AXW = (AW > SET_IDX_W) ? AW : SET_IDX_W;
  localparam int WXW = (PW > WAY_W) ? PW : WAY_W;

  logic                    mem_busy;
  logic [WAYS-1:0][PW-1:0] rd_row;
  logic [WAYS-1:0][PW-1:0] cur_row;
  logic [WAYS-1:0][PW-1:0] upd_row;
  logic                    upd_we;
  tlru_res_t               upd_res;

  logic [AXW-1:0] in_set_x;
  logic [WXW-1:0] in_way_x;
  logic [AW-1:0]  in_addr;
  logic           in_fire;
  logic           s1_adv;
  logic           wr_en;

  // Update stage
  logic          s1_valid_r;
  tlru_req_t     s1_req_r;
  logic [AW-1:0] s1_addr_r;
  logic [PW-1:0] s1_way_r;

  // Last written row, for forwarding
  logic                    fwd_valid_r;
  logic [AW-1:0]           fwd_addr_r;
  logic [WAYS-1:0][PW-1:0] fwd_row_r;

  // Output register
  logic      out_valid_r;
  tlru_res_t out_res_r;

  // Input decode
  assign in_set_x = AXW'(in_ch.set_index);
  assign in_way_x = WXW'(in_ch.way);
  assign in_addr  = in_set_x[AW-1:0];

  // Handshake
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !mem_busy && (!s1_valid_r || s1_adv);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign wr_en       = s1_adv && upd_we;

  tlru_row_mem #(
    .SETS(SETS),
    .WAYS(WAYS)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (in_addr),
    .rd_data (rd_row),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (upd_row),
    .busy    (mem_busy)
  );

  // Forward the last written row on a set match; this covers a write at the read's own edge
  assign cur_row = (fwd_valid_r && (fwd_addr_r == s1_addr_r)) ? fwd_row_r : rd_row;

  tlru_row_update #(
    .WAYS(WAYS)
  ) u_upd (
    .req     (s1_req_r),
    .way_idx (s1_way_r),
    .row     (cur_row),
    .new_row (upd_row),
    .row_we  (upd_we),
    .res     (upd_res)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (wr_en) begin
        fwd_valid_r <= 1'b1;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r.kind   <= in_ch.kind;
      s1_req_r.set_ok <= (32'(in_ch.set_index) < 32'(SETS));
      s1_req_r.way_ok <= (32'(in_ch.way) < 32'(WAYS));
      s1_addr_r       <= in_addr;
      s1_way_r        <= in_way_x[PW-1:0];
    end
    if (wr_en) begin
      fwd_addr_r <= s1_addr_r;
      fwd_row_r  <= upd_row;
    end
    if (s1_adv) begin
      out_res_r <= upd_res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.evict_way      = out_res_r.evict_way;
  assign out_ch.prior_position = out_res_r.prior_position;

endmodule

// File: rtl/tlru_checker.sv
// Port-level checker of the true-LRU replacement unit, with its bind.
// Depends on tlru_pkg and true_lru_stack_replacement_unit_defines.svh.
`include "true_lru_stack_replacement_unit_defines.svh"

module tlru_checker import tlru_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] out_evict_way,
  input logic [OUT_W-1:0] out_prior_position
);

  // A stalled result holds
  `TLRU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_evict_way) && $stable(out_prior_position))

  // A result carries a victim or a prior position, never both
  `TLRU_ASSERT_IMPL(a_one_field, clk, rst_n, out_valid, (out_evict_way == '0) || (out_prior_position == '0))

  // A new result is traced back to an input transfer through the update stage
  `TLRU_ASSERT_IMPL(a_rose_src, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2))

  // Right after reset the clearing sweep blocks input and no result shows
  `TLRU_ASSERT_IMPL(a_post_reset, clk, rst_n, !$past(rst_n), !in_ready && !out_valid)

endmodule

bind true_lru_stack_replacement_unit tlru_checker u_tlru_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_evict_way      (out_ch.evict_way),
  .out_prior_position (out_ch.prior_position)
);
